[hw/rtl/va_range_first_fit_allocator_assert.svh]
// Assertion macros for the VA range allocator.
// Used by the top level through a plain include.
`ifndef VA_RANGE_FIRST_FIT_ALLOCATOR_ASSERT_SVH
`define VA_RANGE_FIRST_FIT_ALLOCATOR_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define VA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication.
`define VA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

[hw/rtl/vaff_pkg.sv]
// Package for the VA range allocator: payload structs and status codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package vaff_pkg;
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NOFIT = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic       KIND_ALLOC = 1'b0;
	localparam logic       KIND_FREE  = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [31:0] size_bytes;
		logic [31:0] address;
	} vaff_req_t;

	typedef struct packed {
		logic [31:0] alloc_address;
		logic [1:0]  status;
	} vaff_rsp_t;
endpackage
`default_nettype wire

[hw/rtl/vaff_hole_ram.sv]
// Hole table memory: one write port, one read port, registered read data.
// Depends on nothing; widths set by the instantiating level.
`timescale 1ns / 1ps
`default_nettype none
module vaff_hole_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int DW    = 41
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);
	logic [DW-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[hw/rtl/va_range_first_fit_allocator.sv]
// Each hole table entry walked or shifted takes a read state and an evaluate or write
// state; the response is presented once the walk and any shift of the table are done.
// One transaction at a time: a new request is accepted only in the idle state, and the
// state machine returns there only after the response has been taken.
// Reset: the hole count (cnt_q) is 1 and entry 0 is written with the whole space in the
// init state after reset, while the input is held not ready.
// Top level of the VA range allocator; uses vaff_pkg, vaff_hole_ram and the
// assertion header.
`timescale 1ns / 1ps
`default_nettype none
`include "va_range_first_fit_allocator_assert.svh"
module va_range_first_fit_allocator #(
	parameter int PAGE_BITS  = 12,
	parameter int HOLE_SLOTS = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire vaff_pkg::vaff_req_t in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output vaff_pkg::vaff_rsp_t    out_data
);
	import vaff_pkg::*;

	localparam int SW = 32 - PAGE_BITS;
	localparam int CW = 33 - PAGE_BITS;
	localparam int AW = (HOLE_SLOTS > 1) ? $clog2(HOLE_SLOTS) : 1;
	localparam int NW = $clog2(HOLE_SLOTS + 1);
	localparam int DW = SW + CW;
	localparam logic [NW-1:0] SLOTS_N = NW'(HOLE_SLOTS);
	localparam logic [CW-1:0] SPACE_PAGES = {1'b1, {SW{1'b0}}};

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_RD, S_EVAL, S_NXT_RD, S_NXT_EVAL,
		S_SHR_RD, S_SHR_WR, S_SHL_RD, S_SHL_WR, S_RESP
	} state_t;

	state_t          state_q;
	logic            kind_q;
	logic [CW-1:0]   pages_q;
	logic [SW-1:0]   va_q;
	logic [NW-1:0]   cnt_q;
	logic [NW-1:0]   idx_q;
	logic [NW-1:0]   sh_q;
	logic [SW-1:0]   s_q;
	logic [CW-1:0]   c_q;
	vaff_rsp_t       rsp_q;

	logic            we;
	logic [AW-1:0]   waddr, raddr;
	logic [DW-1:0]   wdata, rdata;

	vaff_hole_ram #(.DEPTH(HOLE_SLOTS), .AW(AW), .DW(DW)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	logic [SW-1:0] rs;
	logic [CW-1:0] rc;
	logic [CW:0]   fend;
	logic [CW:0]   hend;
	logic [CW:0]   grow_sum;
	logic [CW:0]   shrink_start;
	logic [CW+1:0] merge_sum;
	logic          last;
	logic          nxt_match;
	logic [CW-1:0] pages_in;
	assign rs = rdata[DW-1:CW];
	assign rc = rdata[CW-1:0];
	assign fend = (CW+1)'(va_q) + (CW+1)'(pages_q);
	assign hend = (CW+1)'(rs) + (CW+1)'(rc);
	assign grow_sum = (CW+1)'(rc) + (CW+1)'(pages_q);
	assign shrink_start = (CW+1)'(rs) + (CW+1)'(pages_q);
	assign nxt_match = ((CW+1)'(rs) == fend);
	// merged count: the hole, the freed range and, when it touches, the next hole
	assign merge_sum = (CW+2)'(c_q) + (CW+2)'(pages_q)
		+ (nxt_match ? (CW+2)'(rc) : {(CW+2){1'b0}});
	assign last = (idx_q + NW'(1) == cnt_q);
	// pages = ceil(bytes / page); result fits in CW bits
	assign pages_in = CW'(({1'b0, in_data.size_bytes} + 33'((64'd1 << PAGE_BITS) - 1))
		>> PAGE_BITS);

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_RESP);
	assign out_data  = rsp_q;

	// memory port control
	always_comb begin
		we = 1'b0;
		waddr = AW'(idx_q);
		wdata = '0;
		raddr = AW'(idx_q);
		unique case (state_q)
			S_INIT: begin
				we = 1'b1;
				waddr = '0;
				wdata = {{SW{1'b0}}, SPACE_PAGES};
			end
			// in-place updates of the hole under the walk
			S_EVAL: begin
				if (kind_q == KIND_ALLOC) begin
					if (rc > pages_q) begin
						we = 1'b1;
						wdata = {shrink_start[SW-1:0], rc - pages_q};
					end
				end else if (fend == (CW+1)'(rs)) begin
					we = 1'b1;
					wdata = {va_q, grow_sum[CW-1:0]};
				end else if (fend > (CW+1)'(rs) && (CW+1)'(va_q) == hend && last) begin
					we = 1'b1;
					wdata = {rs, grow_sum[CW-1:0]};
				end
			end
			S_NXT_RD: raddr = AW'(idx_q + NW'(1));
			S_NXT_EVAL: begin
				we = 1'b1;
				wdata = {s_q, merge_sum[CW-1:0]};
			end
			S_SHR_RD: begin
				if (sh_q == idx_q) begin
					we = 1'b1;
					wdata = {va_q, pages_q};
				end else raddr = AW'(sh_q - NW'(1));
			end
			S_SHR_WR: begin
				we = 1'b1; waddr = AW'(sh_q); wdata = rdata;
			end
			S_SHL_RD: raddr = AW'(sh_q + NW'(1));
			S_SHL_WR: begin
				we = 1'b1; waddr = AW'(sh_q); wdata = rdata;
			end
			default: ;
		endcase
	end

	// main sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			cnt_q <= NW'(1);
			idx_q <= '0;
			sh_q <= '0;
			kind_q <= 1'b0;
			pages_q <= '0;
			va_q <= '0;
			s_q <= '0;
			c_q <= '0;
			rsp_q <= '{alloc_address: 32'd0, status: ST_OK};
		end else begin
			unique case (state_q)
				S_INIT: state_q <= S_IDLE;
				S_IDLE: if (in_valid) begin
					kind_q <= in_data.kind;
					pages_q <= pages_in;
					va_q <= in_data.address[31 -: SW];
					idx_q <= '0;
					sh_q <= '0;
					rsp_q <= '{alloc_address: 32'd0,
						status: (cnt_q == '0 && in_data.kind == KIND_ALLOC) ? ST_NOFIT : ST_OK};
					if (cnt_q == '0)
						state_q <= (in_data.kind == KIND_ALLOC) ? S_RESP : S_SHR_RD;
					else
						state_q <= S_RD;
				end
				S_RD: state_q <= S_EVAL;
				S_EVAL: begin
					s_q <= rs;
					c_q <= rc;
					if (kind_q == KIND_ALLOC) begin
						if (rc >= pages_q) begin
							rsp_q.alloc_address <= 32'(rs) << PAGE_BITS;
							if (rc == pages_q) begin
								sh_q <= idx_q;
								state_q <= S_SHL_RD;
							end else state_q <= S_RESP;
						end else if (!last) begin
							idx_q <= idx_q + NW'(1);
							state_q <= S_RD;
						end else begin
							rsp_q.status <= ST_NOFIT;
							state_q <= S_RESP;
						end
					end else begin
						priority if (fend == (CW+1)'(rs)) begin
							state_q <= S_RESP;
						end else if (fend < (CW+1)'(rs)) begin
							// insert before this hole
							if (cnt_q >= SLOTS_N) begin
								rsp_q.status <= ST_FULL;
								state_q <= S_RESP;
							end else begin
								sh_q <= cnt_q;
								state_q <= S_SHR_RD;
							end
						end else if ((CW+1)'(va_q) == hend) begin
							state_q <= last ? S_RESP : S_NXT_RD;
						end else if ((CW+1)'(va_q) > hend && last) begin
							// append after the last hole
							if (cnt_q >= SLOTS_N) begin
								rsp_q.status <= ST_FULL;
								state_q <= S_RESP;
							end else begin
								idx_q <= cnt_q;
								sh_q <= cnt_q;
								state_q <= S_SHR_RD;
							end
						end else if (!last) begin
							idx_q <= idx_q + NW'(1);
							state_q <= S_RD;
						end else state_q <= S_RESP;
					end
				end
				S_NXT_RD: state_q <= S_NXT_EVAL;
				// absorb the following hole if it starts at the freed end
				S_NXT_EVAL: begin
					if (nxt_match) begin
						sh_q <= idx_q + NW'(1);
						state_q <= S_SHL_RD;
					end else state_q <= S_RESP;
				end
				// shift entries up from the top down to the insert slot
				S_SHR_RD: begin
					if (sh_q == idx_q) begin
						cnt_q <= cnt_q + NW'(1);
						state_q <= S_RESP;
					end else state_q <= S_SHR_WR;
				end
				S_SHR_WR: begin
					sh_q <= sh_q - NW'(1);
					state_q <= S_SHR_RD;
				end
				// shift entries down over a removed slot
				S_SHL_RD: begin
					if (sh_q + NW'(1) < cnt_q) state_q <= S_SHL_WR;
					else begin
						cnt_q <= cnt_q - NW'(1);
						state_q <= S_RESP;
					end
				end
				S_SHL_WR: begin
					sh_q <= sh_q + NW'(1);
					state_q <= S_SHL_RD;
				end
				S_RESP: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`VA_ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= SLOTS_N)
	`VA_ASSERT_IMP(a_excl, clk, arst_n, 1'b1, !(in_ready && out_valid))
	`VA_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
	`VA_ASSERT_IMP(a_full_cnt, clk, arst_n, out_valid && out_data.status == ST_FULL, cnt_q == SLOTS_N)
endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking testbench for va_range_first_fit_allocator: directed table, a fragmenting
// pass, then random allocate/free traffic checked against an internal first-fit hole table predictor.
// Depends on vaff_pkg and the allocator RTL.
`timescale 1ns / 1ps
module tb_top;
	import vaff_pkg::*;

	localparam int PAGE_BITS  = 12;
	localparam int HOLE_SLOTS = 64;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int TAIL_CYCLES = 3 * HOLE_SLOTS + 60;
	localparam int RAND_ITEMS  = 880;
	localparam longint START_MASK = (64'd1 << (32 - PAGE_BITS)) - 1;
	localparam longint COUNT_MASK = (64'd1 << (33 - PAGE_BITS)) - 1;
	localparam longint PAGE_MASK  = (64'd1 << PAGE_BITS) - 1;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	vaff_req_t in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	vaff_rsp_t out_data;

	va_range_first_fit_allocator #(
		.PAGE_BITS(PAGE_BITS),
		.HOLE_SLOTS(HOLE_SLOTS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predicted hole table
	longint    hole_start[HOLE_SLOTS];
	longint    hole_pages[HOLE_SLOTS];
	int        holes_used;
	vaff_rsp_t pending_rsp[$];
	int        errors = 0;
	int        cycles = 0;
	int        burst_left = 0;

	// live allocations, for well-formed frees
	logic [31:0] live_addr[$];
	longint      live_pages[$];

	function automatic void set_hole(int i, longint s, longint c);
		hole_start[i] = s & START_MASK;
		hole_pages[i] = c & COUNT_MASK;
	endfunction

	function automatic logic [1:0] add_hole(int pos, longint s, longint c);
		if (holes_used >= HOLE_SLOTS)
			return ST_FULL;
		for (int i = holes_used; i > pos; i--) begin
			hole_start[i] = hole_start[i-1];
			hole_pages[i] = hole_pages[i-1];
		end
		set_hole(pos, s, c);
		holes_used++;
		return ST_OK;
	endfunction

	function automatic void drop_hole(int pos);
		for (int i = pos; i + 1 < holes_used; i++) begin
			hole_start[i] = hole_start[i+1];
			hole_pages[i] = hole_pages[i+1];
		end
		holes_used--;
	endfunction

	// first-fit allocate / coalescing free, updating the predicted table
	function automatic vaff_rsp_t predict_hole_update(vaff_req_t r);
		vaff_rsp_t rsp;
		longint pages, va, fend, s, c, hend, grow;
		bit last;
		rsp = '0;
		rsp.status = ST_OK;
		pages = (longint'(r.size_bytes) + PAGE_MASK) >> PAGE_BITS;
		if (r.kind == KIND_ALLOC) begin
			rsp.status = ST_NOFIT;
			for (int i = 0; i < holes_used; i++) begin
				s = hole_start[i];
				c = hole_pages[i];
				if (c >= pages) begin
					rsp.alloc_address = 32'((s << PAGE_BITS) & 64'hFFFF_FFFF);
					rsp.status = ST_OK;
					if (c == pages)
						drop_hole(i);
					else
						set_hole(i, s + pages, c - pages);
					break;
				end
			end
		end else begin
			va = longint'(r.address) >> PAGE_BITS;
			fend = va + pages;
			if (holes_used == 0) begin
				rsp.status = add_hole(0, va, pages);
			end else begin
				for (int i = 0; i < holes_used; i++) begin
					s = hole_start[i];
					c = hole_pages[i];
					hend = s + c;
					last = (i + 1 == holes_used);
					if (fend == s) begin
						set_hole(i, va, c + pages);
						break;
					end else if (fend < s) begin
						rsp.status = add_hole(i, va, pages);
						break;
					end else if (va == hend) begin
						grow = pages;
						if (!last && hole_start[i+1] == fend) begin
							grow += hole_pages[i+1];
							drop_hole(i + 1);
						end
						set_hole(i, s, c + grow);
						break;
					end else if (va > hend && last) begin
						rsp.status = add_hole(holes_used, va, pages);
						break;
					end
				end
			end
		end
		return rsp;
	endfunction

	// drive one transaction; the expected response comes from the table row when given
	task automatic send_request(vaff_req_t r, bit typed, vaff_rsp_t typed_rsp,
			output vaff_rsp_t granted);
		vaff_rsp_t exp_rsp;
		exp_rsp = predict_hole_update(r);
		if (typed)
			exp_rsp = typed_rsp;
		granted = exp_rsp;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		in_valid <= 1'b1;
		in_data <= r;
		do @(posedge clk); while (!in_ready);
		pending_rsp.push_back(exp_rsp);
		burst_left--;
	endtask

	task automatic send_alloc(logic [31:0] bytes);
		vaff_req_t r;
		vaff_rsp_t g;
		longint pages;
		r.kind = KIND_ALLOC;
		r.size_bytes = bytes;
		r.address = $urandom;
		send_request(r, 1'b0, '0, g);
		pages = (longint'(bytes) + PAGE_MASK) >> PAGE_BITS;
		if (g.status == ST_OK && pages > 0) begin
			live_addr.push_back(g.alloc_address);
			live_pages.push_back(pages);
		end
	endtask

	task automatic send_free(logic [31:0] addr, logic [31:0] bytes);
		vaff_req_t r;
		vaff_rsp_t g;
		r.kind = KIND_FREE;
		r.size_bytes = bytes;
		r.address = addr;
		send_request(r, 1'b0, '0, g);
	endtask

	// give back a live allocation with random sub-page slack in address and size
	task automatic free_live(int idx);
		logic [31:0] a;
		longint p;
		a = live_addr[idx] | 32'($urandom_range(0, 4095));
		p = live_pages[idx];
		live_addr.delete(idx);
		live_pages.delete(idx);
		send_free(a, 32'((p << PAGE_BITS) - $urandom_range(0, 4095)));
	endtask

	typedef struct {
		vaff_req_t req;
		bit        typed;
		vaff_rsp_t rsp;
	} stim_row_t;

	stim_row_t stim_rows[$];

	function automatic void add_row(logic kind, logic [31:0] bytes, logic [31:0] addr,
			bit typed, logic [31:0] ga, logic [1:0] st);
		stim_row_t row;
		row.req = '{kind: kind, size_bytes: bytes, address: addr};
		row.typed = typed;
		row.rsp = '{alloc_address: ga, status: st};
		stim_rows.push_back(row);
	endfunction

	// result checker
	always @(posedge clk) begin
		vaff_rsp_t exp_rsp;
		if (arst_n && out_valid && out_ready) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected transaction, actual %h/%0d", $time,
					out_data.alloc_address, out_data.status);
				errors++;
			end else begin
				exp_rsp = pending_rsp.pop_front();
				if (out_data.alloc_address !== exp_rsp.alloc_address) begin
					$display("%0t: alloc_address expected %h actual %h", $time,
						exp_rsp.alloc_address, out_data.alloc_address);
					errors++;
				end
				if (out_data.status !== exp_rsp.status) begin
					$display("%0t: status expected %0d actual %0d", $time,
						exp_rsp.status, out_data.status);
					errors++;
				end
			end
		end
	end

	// receiver back-pressure: one of four ready patterns, re-picked at random
	int ready_mode = 0;
	int ready_left = 0;
	always @(posedge clk) begin
		if (ready_left == 0) begin
			ready_mode = $urandom_range(0, 3);
			ready_left = $urandom_range(16, 128);
		end
		ready_left--;
		case (ready_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= $urandom_range(0, 1);
			2: out_ready <= ($urandom_range(0, 3) != 0);
			default: out_ready <= ~out_ready;
		endcase
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		vaff_rsp_t g;
		int frag_n;
		int pick;
		logic [31:0] frag_addr[$];

		holes_used = 1;
		hole_start[0] = 0;
		hole_pages[0] = 64'd1 << (32 - PAGE_BITS);

		// directed rows; typed responses only where obvious from the table state
		add_row(KIND_ALLOC, 32'h0000_0000, 32'h0, 1, 32'h0000_0000, ST_OK);     // zero size
		add_row(KIND_ALLOC, 32'h0000_0001, 32'h0, 1, 32'h0000_0000, ST_OK);
		add_row(KIND_ALLOC, 32'hFFFF_FFFF, 32'h0, 1, 32'h0000_0000, ST_NOFIT);
		add_row(KIND_ALLOC, 32'h0000_1000, 32'h0, 1, 32'h0000_1000, ST_OK);
		add_row(KIND_FREE,  32'h0000_1000, 32'h0, 1, 32'h0, ST_OK);            // insert before
		add_row(KIND_FREE,  32'h0000_1000, 32'h1000, 1, 32'h0, ST_OK);         // merge both sides
		add_row(KIND_ALLOC, 32'h0000_1000, 32'h0, 1, 32'h0000_0000, ST_OK);
		add_row(KIND_FREE,  32'h0000_0000, 32'h0001_2345, 1, 32'h0, ST_OK);    // overlap, no change
		add_row(KIND_ALLOC, 32'hFFFF_F000, 32'h0, 1, 32'h0000_1000, ST_OK);    // exact fit, empties
		add_row(KIND_ALLOC, 32'h0000_0001, 32'h0, 1, 32'h0, ST_NOFIT);         // empty table
		add_row(KIND_FREE,  32'hFFFF_FFFF, 32'h0, 1, 32'h0, ST_OK);            // whole space back
		add_row(KIND_FREE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'h0, ST_OK);    // overlap, top
		add_row(KIND_ALLOC, 32'h7FFF_F001, 32'h0, 0, 32'h0, ST_OK);
		add_row(KIND_ALLOC, 32'h0000_3000, 32'h0, 0, 32'h0, ST_OK);
		add_row(KIND_FREE,  32'h0000_2000, 32'h0000_0FFF, 0, 32'h0, ST_OK);
		add_row(KIND_FREE,  32'h0000_0000, 32'h9000_0000, 0, 32'h0, ST_OK);    // zero-size hole
		add_row(KIND_FREE,  32'h0000_1000, 32'h8000_1000, 0, 32'h0, ST_OK);
		add_row(KIND_ALLOC, 32'h0000_0000, 32'hFFFF_FFFF, 0, 32'h0, ST_OK);
		add_row(KIND_FREE,  32'h8000_2000, 32'h0, 0, 32'h0, ST_OK);
		add_row(KIND_FREE,  32'h0000_1000, 32'hFFFF_F000, 0, 32'h0, ST_OK);    // past the end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[i])
			send_request(stim_rows[i].req, stim_rows[i].typed, stim_rows[i].rsp, g);

		// fragment the space into single pages to drive the table to full
		for (int i = 0; i < 2 * HOLE_SLOTS + 4; i++) begin
			send_alloc(32'h0000_1000);
			frag_addr.push_back(live_addr[live_addr.size() - 1]);
		end
		for (int i = 0; i < frag_addr.size(); i += 2) begin
			foreach (live_addr[j])
				if (live_addr[j] == frag_addr[i]) begin
					pick = j;
					break;
				end
			free_live(pick);
		end

		// random mix: mostly allocations and well-formed frees, some noise
		for (int n = 0; n < RAND_ITEMS; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				frag_n = $urandom_range(0, 9);
				if (frag_n < 7)
					send_alloc(32'($urandom_range(1, 16) * 4096 - $urandom_range(0, 4095)));
				else if (frag_n == 7)
					send_alloc(32'h0);
				else if (frag_n == 8)
					send_alloc($urandom);
				else
					send_alloc(32'($urandom_range(1, 4096) * 4096));
			end else if (pick < 85 && live_addr.size() > 0) begin
				free_live($urandom_range(0, live_addr.size() - 1));
			end else if (pick < 93) begin
				send_free($urandom, $urandom);
			end else begin
				send_free($urandom, 32'($urandom_range(0, 8192)));
			end
		end

		in_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/vaff_pkg.sv
hw/rtl/vaff_hole_ram.sv
hw/rtl/va_range_first_fit_allocator.sv
tb/sv/tb_top.sv
